@@ rtl/core/cda_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar date adder.
package cda_pkg;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] amount;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
  } in_t;

  typedef struct packed {
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [2:0] {
    CMD_DAYS       = 3'd0,
    CMD_WEEKS      = 3'd1,
    CMD_MONTHS     = 3'd2,
    CMD_YEARS      = 3'd3,
    CMD_DECADES    = 3'd4,
    CMD_CENTURIES  = 3'd5,
    CMD_MILLENNIA  = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_RUN,
    S_FINISH
  } state_e;

  // working date plus year mod 400 and the remaining step count
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  ymod;
    logic [14:0] cnt;
  } ctx_t;

  localparam logic [13:0] MaxYear       = 14'd9999;
  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [3:0]  MonthFeb      = 4'd2;
  localparam logic [4:0]  LeapDay       = 5'd29;
  localparam logic [4:0]  FebDays       = 5'd28;
  localparam logic [9:0]  YearCycle     = 10'd400;
  // year mod 400 is found by conditional subtraction of 400 << 4 .. 400 << 0
  localparam int          ReduceSteps   = 5;
  localparam logic [13:0] ReduceTop     = 14'd6400;

  // leap test on the year taken mod 400
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r == 9'd0) ||
              ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MonthFeb:                                  len = leap ? LeapDay : FebDays;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // (r + inc) mod 400 for r < 400, inc < 400
  function automatic logic [8:0] mod_add(input logic [8:0] r, input logic [8:0] inc);
    logic [9:0] s;
    s = {1'b0, r} + {1'b0, inc};
    if (s >= YearCycle) s = s - YearCycle;
    return s[8:0];
  endfunction

endpackage

@@ rtl/core/cda_step.sv @@
// Shared step unit: advances the working date by one month hop, the remaining days within a month, or one year unit.
module cda_step (
  input  cda_pkg::ctx_t cur_i,
  input  logic [2:0]    cmd_i,
  output cda_pkg::ctx_t nxt_o
);
  import cda_pkg::*;

  logic        wrap;
  logic [3:0]  m_adv;
  logic [13:0] y_adv;
  logic [8:0]  mod_adv;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_adv;
  logic [4:0]  left;
  logic [13:0] y_unit;
  logic [8:0]  mod_unit;
  logic [8:0]  mod_yr;

  always_comb begin
    wrap    = (cur_i.month == MonthsPerYear);
    m_adv   = wrap ? 4'd1 : cur_i.month + 4'd1;
    y_adv   = wrap ? cur_i.year + 14'd1 : cur_i.year;
    mod_adv = wrap ? mod_add(cur_i.ymod, 9'd1) : cur_i.ymod;
    dim_cur = days_in(cur_i.month, is_leap(cur_i.ymod));
    dim_adv = days_in(m_adv, is_leap(mod_adv));
    left    = dim_cur - cur_i.day;

    case (cmd_e'(cmd_i))
      CMD_DECADES:   begin y_unit = 14'd10;   mod_unit = 9'd10;  end
      CMD_CENTURIES: begin y_unit = 14'd100;  mod_unit = 9'd100; end
      CMD_MILLENNIA: begin y_unit = 14'd1000; mod_unit = 9'd200; end
      default:       begin y_unit = 14'd1;    mod_unit = 9'd1;   end
    endcase
    mod_yr = mod_add(cur_i.ymod, mod_unit);

    nxt_o = cur_i;
    case (cmd_e'(cmd_i))
      CMD_DAYS, CMD_WEEKS: begin
        if (cur_i.cnt <= {10'd0, left}) begin
          nxt_o.day = cur_i.day + cur_i.cnt[4:0];
          nxt_o.cnt = '0;
        end else begin
          // hop to the first of the next month
          nxt_o.cnt   = cur_i.cnt - {10'd0, left} - 15'd1;
          nxt_o.day   = 5'd1;
          nxt_o.month = m_adv;
          nxt_o.year  = y_adv;
          nxt_o.ymod  = mod_adv;
        end
      end
      CMD_MONTHS: begin
        nxt_o.month = m_adv;
        nxt_o.year  = y_adv;
        nxt_o.ymod  = mod_adv;
        nxt_o.day   = (cur_i.day > dim_adv) ? dim_adv : cur_i.day;
        nxt_o.cnt   = cur_i.cnt - 15'd1;
      end
      CMD_YEARS, CMD_DECADES, CMD_CENTURIES, CMD_MILLENNIA: begin
        nxt_o.year = cur_i.year + y_unit;
        nxt_o.ymod = mod_yr;
        if ((cur_i.month == MonthFeb) && (cur_i.day == LeapDay) && !is_leap(mod_yr))
          nxt_o.day = FebDays;
        nxt_o.cnt = cur_i.cnt - 15'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/calendar_date_adder.sv @@
// Calendar date adder: adds days, weeks, months or year units to a Gregorian date.
//
// Input channel: in_valid_i / in_stall_o carry one item (unit, amount, start date).
// Output channel: out_valid_o / out_stall_i return one item per input item with the
// end date and a status (ok, invalid input date, year overflow past 9999).
// An item is taken when valid is high and stall is low at a rising edge.
//
// One item is handled at a time. After acceptance the year is reduced mod 400 in
// the reduce state, the start date is checked in the check state, then the shared
// step unit runs one step per cycle: one month hop for days and weeks (about amount/30
// steps, seven times that for weeks), one month for months, one unit for years and
// above (amount steps). The next item can be taken in the cycle after the result is
// registered. Work stops early once the year passes 9999.
//
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls and a new result is done, the block holds in its finish
// state until the output register frees up. Reset clears the sequencer and the
// output valid; no item is pending after reset.
module calendar_date_adder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cda_pkg::in_t   in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cda_pkg::out_t  out_item_o
);
  import cda_pkg::*;

  state_e      state_q, state_d;
  in_t         in_q;
  ctx_t        ctx_q, ctx_nxt;
  logic [13:0] rem_q;
  logic [2:0]  k_q;
  logic        invalid_q;
  logic        out_valid_q;
  out_t        out_q;

  logic        accept;
  logic        red_last;
  logic [13:0] red_sub;
  logic        date_ok;
  logic        run_done;
  logic        out_free;
  logic        overflow;

  cda_step u_step (
    .cur_i (ctx_q),
    .cmd_i (in_q.command),
    .nxt_o (ctx_nxt)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign red_last = (k_q == 3'(ReduceSteps - 1));
  assign red_sub  = ReduceTop >> k_q;
  assign date_ok  = (in_q.start_year >= 14'd1) && (in_q.start_year <= MaxYear) &&
                    (in_q.start_day >= 5'd1) &&
                    (in_q.start_day <= days_in(in_q.start_month, is_leap(rem_q[8:0])));
  assign overflow = (ctx_q.year > MaxYear);
  assign run_done = (ctx_q.cnt == 15'd0) || overflow ||
                    (cmd_e'(in_q.command) == CMD_NONE);
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_REDUCE;
      S_REDUCE: if (red_last) state_d = S_CHECK;
      S_CHECK:  state_d = date_ok ? S_RUN : S_FINISH;
      S_RUN:    if (run_done) state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = out_valid_q;
    out_item_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      invalid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) k_q <= '0;
      else if (state_q == S_REDUCE) k_q <= k_q + 3'd1;
      if (state_q == S_CHECK) invalid_q <= !date_ok;
      if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q  <= in_item_i;
      rem_q <= in_item_i.start_year;
    end
    if (state_q == S_REDUCE && rem_q >= red_sub) rem_q <= rem_q - red_sub;

    if (state_q == S_CHECK) begin
      ctx_q.year  <= in_q.start_year;
      ctx_q.month <= in_q.start_month;
      ctx_q.day   <= in_q.start_day;
      ctx_q.ymod  <= rem_q[8:0];
      if (cmd_e'(in_q.command) == CMD_WEEKS)
        ctx_q.cnt <= {in_q.amount, 3'b000} - {3'b000, in_q.amount};
      else
        ctx_q.cnt <= {3'b000, in_q.amount};
    end else if (state_q == S_RUN && !run_done) begin
      ctx_q <= ctx_nxt;
    end

    if (state_q == S_FINISH && out_free) begin
      if (invalid_q || overflow) begin
        out_q.end_year  <= in_q.start_year;
        out_q.end_month <= in_q.start_month;
        out_q.end_day   <= in_q.start_day;
        out_q.status    <= invalid_q ? STAT_INVALID : STAT_OVERFLOW;
      end else begin
        out_q.end_year  <= ctx_q.year;
        out_q.end_month <= ctx_q.month;
        out_q.end_day   <= ctx_q.day;
        out_q.status    <= STAT_OK;
      end
    end
  end

endmodule

@@ tb/tb_calendar_date_adder.sv @@
// Self-checking testbench for the calendar date adder: directed edge dates, then random items.
module tb_calendar_date_adder;
  import cda_pkg::*;

  localparam int unsigned CycleLimit = 10_000_000;
  localparam int unsigned TailCycles = 64;
  localparam int unsigned LastYear   = 9999;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_item   = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b1;
  out_t out_item;

  out_t        pending_dates[$];
  int unsigned fail_count     = 0;
  int unsigned dates_checked  = 0;
  int unsigned ok_count       = 0;
  int unsigned invalid_count  = 0;
  int unsigned overflow_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_run      = 0;
  int unsigned stall_mode     = 0;
  int unsigned unit_sent[8]   = '{default: 0};

  calendar_date_adder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #1 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Expected end date and status for one item.
  function automatic out_t advance_date(input in_t it);
    int unsigned y, m, d, n, left, span;
    status_e     st;
    out_t        res;
    y    = it.start_year;
    m    = it.start_month;
    d    = it.start_day;
    st   = STAT_OK;
    span = 0;
    if (y < 1 || y > LastYear || m < 1 || m > 12 || d < 1 || d > month_length(m, y)) begin
      st = STAT_INVALID;
    end else begin
      case (cmd_e'(it.command))
        CMD_DAYS, CMD_WEEKS: begin
          n = it.amount;
          if (it.command == CMD_WEEKS) n = n * 7;
          // hop a whole month at a time; stop once past the last year
          while (n > 0 && y <= LastYear) begin
            left = month_length(m, y) - d;
            if (n <= left) begin
              d += n;
              n = 0;
            end else begin
              n -= left + 1;
              d = 1;
              if (m == 12) begin
                m = 1;
                y++;
              end else begin
                m++;
              end
            end
          end
        end
        CMD_MONTHS: begin
          // clamp after every step, so a short month carries forward
          repeat (it.amount) begin
            if (m == 12) begin
              m = 1;
              y++;
            end else begin
              m++;
            end
            if (d > month_length(m, y)) d = month_length(m, y);
          end
        end
        CMD_YEARS:     span = 1;
        CMD_DECADES:   span = 10;
        CMD_CENTURIES: span = 100;
        CMD_MILLENNIA: span = 1000;
        default: ;
      endcase
      if (span != 0) begin
        repeat (it.amount) begin
          y += span;
          if (m == 2 && d == 29 && !leap_year(y)) d = 28;
        end
      end
      if (y > LastYear) st = STAT_OVERFLOW;
    end
    if (st != STAT_OK) begin
      y = it.start_year;
      m = it.start_month;
      d = it.start_day;
    end
    res.end_year  = y[13:0];
    res.end_month = m[3:0];
    res.end_day   = d[4:0];
    res.status    = st;
    return res;
  endfunction

  function automatic in_t make_item(input cmd_e c, input int unsigned amt, input int unsigned y,
                                    input int unsigned m, input int unsigned d);
    in_t it;
    it.command     = c;
    it.amount      = amt[11:0];
    it.start_year  = y[13:0];
    it.start_month = m[3:0];
    it.start_day   = d[4:0];
    return it;
  endfunction

  // Mostly valid dates with per-unit amounts kept modest; a few raw items and full amounts.
  function automatic in_t random_date_item();
    in_t         it;
    logic [63:0] raw;
    int unsigned pick, c, y, m, d, cap;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      raw = {$urandom, $urandom};
      it  = raw[$bits(in_t)-1:0];
      return it;
    end
    c = (pick == 2) ? CMD_NONE : $urandom_range(0, 6);
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(9990, 9999);
      1:       y = $urandom_range(1, 12);
      2:       y = 4 * $urandom_range(1, 2499);
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0:       d = month_length(m, y);
      1:       d = 1;
      default: d = $urandom_range(1, month_length(m, y));
    endcase
    if (y % 4 == 0 && $urandom_range(0, 4) == 0) begin
      m = 2;
      d = 29;  // invalid on a plain century year
    end
    case (c)
      CMD_DAYS:      cap = 400;
      CMD_WEEKS:     cap = 60;
      CMD_MONTHS:    cap = 30;
      CMD_YEARS:     cap = 60;
      CMD_DECADES:   cap = 20;
      CMD_CENTURIES: cap = 12;
      CMD_MILLENNIA: cap = 9;
      default:       cap = 4095;
    endcase
    if ($urandom_range(0, 7) == 0) cap = 4095;
    return make_item(cmd_e'(c[2:0]), $urandom_range(0, cap), y, m, d);
  endfunction

  // Sends one item; bursts of random length separated by random gaps.
  task automatic send_date(input in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(advance_date(it));
    unit_sent[it.command]++;
  endtask

  task automatic wait_for_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero_and_unused();
    send_date(make_item(CMD_DAYS, 0, 2000, 2, 29));
    send_date(make_item(CMD_NONE, 4095, 9999, 12, 31));
  endtask

  task automatic test_day_rollover();
    send_date(make_item(CMD_DAYS, 1, 1999, 12, 31));
    send_date(make_item(CMD_DAYS, 1, 9999, 12, 31));
    send_date(make_item(CMD_DAYS, 4095, 1, 1, 1));
    send_date(make_item(CMD_WEEKS, 4095, 2024, 2, 28));
  endtask

  task automatic test_month_clamp();
    send_date(make_item(CMD_MONTHS, 1, 2023, 1, 31));
    send_date(make_item(CMD_MONTHS, 13, 2024, 1, 31));
    send_date(make_item(CMD_MONTHS, 4095, 1, 1, 31));
  endtask

  task automatic test_year_steps();
    send_date(make_item(CMD_YEARS, 1, 2024, 2, 29));
    send_date(make_item(CMD_YEARS, 4, 2024, 2, 29));
    send_date(make_item(CMD_DECADES, 10, 1600, 2, 29));
    // leap day must still clamp when the big units pass a non-leap year
    send_date(make_item(CMD_CENTURIES, 4, 2000, 2, 29));
    send_date(make_item(CMD_MILLENNIA, 7, 2000, 2, 29));
    send_date(make_item(CMD_YEARS, 7999, 2000, 1, 1));
    send_date(make_item(CMD_YEARS, 8000, 2000, 1, 1));
    send_date(make_item(CMD_MILLENNIA, 4095, 1, 1, 1));
  endtask

  task automatic test_invalid_dates();
    send_date(make_item(CMD_DAYS, 5, 0, 6, 15));
    send_date(make_item(CMD_YEARS, 1, 16383, 1, 1));
    send_date(make_item(CMD_MONTHS, 2, 2020, 0, 10));
    send_date(make_item(CMD_WEEKS, 3, 2020, 15, 10));
    send_date(make_item(CMD_DAYS, 1, 2020, 3, 0));
    send_date(make_item(CMD_DECADES, 1, 2021, 4, 31));
    send_date(make_item(CMD_CENTURIES, 1, 1900, 2, 29));
    send_date(make_item(CMD_MILLENNIA, 1, 2020, 13, 31));
  endtask

  task automatic test_random_dates(input int unsigned count);
    repeat (count) send_date(random_date_item());
  endtask

  // Receiver stall pattern: free, light, heavy and solid stretches.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = (stall_mode == 3) ? $urandom_range(1, 16) : $urandom_range(20, 200);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : check_result
    out_t want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result item: %p", out_item);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        dates_checked++;
        case (status_e'(want.status))
          STAT_OK:      ok_count++;
          STAT_INVALID: invalid_count++;
          default:      overflow_count++;
        endcase
        if (out_item.end_year !== want.end_year) begin
          $error("end_year: expected %0d, got %0d", want.end_year, out_item.end_year);
          fail_count++;
        end
        if (out_item.end_month !== want.end_month) begin
          $error("end_month: expected %0d, got %0d", want.end_month, out_item.end_month);
          fail_count++;
        end
        if (out_item.end_day !== want.end_day) begin
          $error("end_day: expected %0d, got %0d", want.end_day, out_item.end_day);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $error("timeout with %0d results outstanding", pending_dates.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_and_unused();
    test_day_rollover();
    test_month_clamp();
    test_year_steps();
    test_invalid_dates();
    wait_for_results();
    test_random_dates(280);
    wait_for_results();
    test_random_dates(275);
    wait_for_results();
    repeat (TailCycles) @(posedge clk);
    $display("Checked %0d dates: %0d ok, %0d invalid input, %0d year overflow.",
             dates_checked, ok_count, invalid_count, overflow_count);
    $display("Items per unit (days weeks months years decades centuries millennia unused):"
             , " %0d %0d %0d %0d %0d %0d %0d %0d", unit_sent[0], unit_sent[1], unit_sent[2],
             unit_sent[3], unit_sent[4], unit_sent[5], unit_sent[6], unit_sent[7]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
